[design/cds_pkg.sv]
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types and constants for the calendar date step block.
// ----------------------------------------------------------------------------
`default_nettype none

package cds_pkg;

    // request codes
    localparam logic REQ_NEXT = 1'b0;
    localparam logic REQ_PREV = 1'b1;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_MAR = 4'd3;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_MAY = 4'd5;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_JUL = 4'd7;
    localparam logic [3:0] MONTH_AUG = 4'd8;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_OCT = 4'd10;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] DAY_FIRST   = 5'd1;
    localparam logic [4:0] DAY_LAST_DEC = 5'd31;

    localparam logic [13:0] YEAR_MIN = 14'd0;
    localparam logic [13:0] YEAR_MAX = 14'd9999;

    // multiplicative inverse of 25 modulo 2^14, and the largest product
    // that a multiple of 25 can give
    localparam logic [13:0] INV25       = 14'd7209;
    localparam logic [13:0] DIV25_LIMIT = 14'd655;

    localparam logic [26:0] YEAR_SCALE = 27'd10000;

    typedef enum logic [1:0] {
        YSTEP_NONE,
        YSTEP_INC,
        YSTEP_DEC
    } ystep_t;

    typedef struct packed {
        logic [13:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic        req_type;
    } date_req_t;

    typedef struct packed {
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [26:0] packed_date;
        logic        input_valid;
        logic        input_leap;
        logic        range_limit;
    } date_rsp_t;

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
        logic [4:0] len;
        case (month)
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC: len = 5'd31;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[design/cds_date_calc.sv]
// ----------------------------------------------------------------------------
// cds_date_calc
// Single-pass date logic: leap test, validity, adjacent date and packed form.
// ----------------------------------------------------------------------------
`default_nettype none

module cds_date_calc
    import cds_pkg::*;
(
    input  wire date_req_t date,
    output date_rsp_t      result
);

    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic        prev;

    logic [13:0] y_inv;
    logic        div4;
    logic        div16;
    logic        div25;
    logic        leap;
    logic [4:0]  mlen;
    logic [4:0]  prev_mlen;
    logic        valid;

    logic [13:0] ry;
    logic [3:0]  rm;
    logic [4:0]  rd;
    logic        limit;
    ystep_t      ystep;

    logic [26:0] year_base;
    logic [26:0] year_part;
    logic [26:0] month_part;

    assign y    = date.in_year;
    assign m    = date.in_month;
    assign d    = date.in_day;
    assign prev = date.req_type;

    // divisible by 25 iff y * inv(25) mod 2^14 lands in the low band
    assign y_inv = y * INV25;
    assign div4  = (y[1:0] == 2'd0);
    assign div16 = (y[3:0] == 4'd0);
    assign div25 = (y_inv <= DIV25_LIMIT);
    // leap: /4 and not /100, or /400 (= /16 and /25)
    assign leap  = (div4 && !div25) || (div16 && div25);

    assign mlen      = month_len(leap, m);
    assign prev_mlen = month_len(leap, m - 4'd1);

    assign valid = (y <= YEAR_MAX) && (m >= MONTH_JAN) && (m <= MONTH_DEC) &&
                   (d >= DAY_FIRST) && (d <= mlen);

    always_comb
    begin
        ry    = y;
        rm    = m;
        rd    = d;
        limit = 1'b0;
        ystep = YSTEP_NONE;
        if (valid)
        begin
            if (prev == REQ_NEXT)
            begin
                if (d < mlen)
                begin
                    rd = d + 5'd1;
                end
                else if (m < MONTH_DEC)
                begin
                    rm = m + 4'd1;
                    rd = DAY_FIRST;
                end
                else if (y < YEAR_MAX)
                begin
                    ry    = y + 14'd1;
                    rm    = MONTH_JAN;
                    rd    = DAY_FIRST;
                    ystep = YSTEP_INC;
                end
                else
                begin
                    limit = 1'b1;
                end
            end
            else
            begin
                if (d > DAY_FIRST)
                begin
                    rd = d - 5'd1;
                end
                else if (m > MONTH_JAN)
                begin
                    rm = m - 4'd1;
                    rd = prev_mlen;
                end
                else if (y > YEAR_MIN)
                begin
                    ry    = y - 14'd1;
                    rm    = MONTH_DEC;
                    rd    = DAY_LAST_DEC;
                    ystep = YSTEP_DEC;
                end
                else
                begin
                    limit = 1'b1;
                end
            end
        end
    end

    // year scaling runs off the input year in parallel with the step logic
    assign year_base = 27'(y) * YEAR_SCALE;

    always_comb
    begin
        case (ystep)
            YSTEP_INC: year_part = year_base + YEAR_SCALE;
            YSTEP_DEC: year_part = year_base - YEAR_SCALE;
            default:   year_part = year_base;
        endcase
    end

    // month * 100 = month * (64 + 32 + 4)
    assign month_part = (27'(rm) << 6) + (27'(rm) << 5) + (27'(rm) << 2);

    always_comb
    begin
        result.out_year    = ry;
        result.out_month   = rm;
        result.out_day     = rd;
        result.packed_date = year_part + month_part + 27'(rd);
        result.input_valid = valid;
        result.input_leap  = leap;
        result.range_limit = limit;
    end

endmodule

`default_nettype wire

[design/calendar_date_step.sv]
// ----------------------------------------------------------------------------
// calendar_date_step
// Next or previous Gregorian day, with validity, leap and range flags.
// ----------------------------------------------------------------------------
// Usage:
//   date channel (date_valid / date_ready / date) carries one request: a
//   year, month, day and the step direction (0 next day, 1 previous day).
//   result channel (result_valid / result_ready / result) returns one item
//   per request: the adjacent date, the date packed as YYYYMMDD and flags.
//   An invalid date or a step outside years 0 to 9999 returns the input.
//   A request is written into the input register when it is accepted,
//   passes once through the date logic and is then loaded into the result
//   register, which drives result_valid. Throughput is one request per
//   cycle; the two registers form a pipeline that keeps moving as long as
//   result_ready is high.
//   When the receiver stalls, the result register holds its item and the
//   input register fills; date_ready drops only when both hold an item.
//   Reset (rst_n low, asynchronous) empties both stages; no request is
//   lost or repeated across a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_step
    import cds_pkg::*;
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            date_valid,
    output logic           date_ready,
    input  wire date_req_t date,
    output logic           result_valid,
    input  wire            result_ready,
    output date_rsp_t      result
);

    logic      s1_valid_reg;
    logic      s1_valid_next;
    date_req_t s1_data_reg;
    logic      s2_valid_reg;
    logic      s2_valid_next;
    date_rsp_t s2_data_reg;
    date_rsp_t calc_result;
    logic      s2_ready;
    logic      s1_load;
    logic      s2_load;

    assign s2_ready   = !s2_valid_reg || result_ready;
    assign date_ready = !s1_valid_reg || s2_ready;
    assign s1_load    = date_valid && date_ready;
    assign s2_load    = s1_valid_reg && s2_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (date_ready)
        begin
            s1_valid_next = date_valid;
        end
        s2_valid_next = s2_valid_reg;
        if (s2_ready)
        begin
            s2_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_data_reg <= date;
        end
        if (s2_load)
        begin
            s2_data_reg <= calc_result;
        end
    end

    cds_date_calc u_calc (
        .date   (s1_data_reg),
        .result (calc_result)
    );

    assign result_valid = s2_valid_reg;
    assign result       = s2_data_reg;

endmodule

`default_nettype wire

[design/cds_checker.sv]
// ----------------------------------------------------------------------------
// cds_checker
// Port-level checks for calendar_date_step, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cds_checker
    import cds_pkg::*;
(
    input wire            clk,
    input wire            rst_n,
    input wire            date_valid,
    input wire            date_ready,
    input wire date_req_t date,
    input wire            result_valid,
    input wire            result_ready,
    input wire date_rsp_t result
);

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    // nothing comes out of reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result_valid high during reset");

    // a draining receiver never blocks a new request
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> date_ready)
        else $error("date_ready low while receiver ready");

    a_limit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.range_limit |-> result.input_valid)
        else $error("range_limit on an invalid date");

    a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.input_valid |->
            result.out_month >= MONTH_JAN && result.out_month <= MONTH_DEC &&
            result.out_day >= DAY_FIRST && result.out_day <= DAY_LAST_DEC)
        else $error("valid request gave an impossible date");

endmodule

bind calendar_date_step cds_checker u_cds_checker (.*);

`default_nettype wire

[tb/tb_calendar_date_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_date_step
// Self-checking bench for the next/previous day block: a directed table of
// calendar edge cases, then random dates under three sender/receiver idle
// mixes; results are checked field by field against written-out or in-bench model values.
// ----------------------------------------------------------------------------

module tb_calendar_date_step
    import cds_pkg::*;
();

    localparam int STALL_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 345;

    typedef struct {
        date_req_t req;
        bit        fixed;
        date_rsp_t rsp;
    } date_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b1;
    logic      date_valid = 1'b0;
    logic      date_ready;
    date_req_t date = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    date_rsp_t result;

    date_rsp_t expected_dates[$];
    date_row_t date_table[$];
    int        errors = 0;
    int        quiet_cycles = 0;
    int        send_idle = 8;
    int        recv_idle = 81;

    calendar_date_step uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .date_valid   (date_valid),
        .date_ready   (date_ready),
        .date         (date),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic is_leap_year(input logic [13:0] y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic logic [4:0] month_days(input logic [13:0] y, input logic [3:0] m);
        logic [4:0] n;
        case (m)
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC: n = 5'd31;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = 5'd30;
            MONTH_FEB: n = is_leap_year(y) ? 5'd29 : 5'd28;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic date_rsp_t step_date(input date_req_t q);
        date_rsp_t  r;
        logic [4:0] len;
        logic       ok;
        logic [31:0] pk;
        len = month_days(q.in_year, q.in_month);
        ok = (q.in_year <= YEAR_MAX) && (q.in_month >= MONTH_JAN) &&
             (q.in_month <= MONTH_DEC) && (q.in_day >= DAY_FIRST) && (q.in_day <= len);
        r = '0;
        r.out_year = q.in_year;
        r.out_month = q.in_month;
        r.out_day = q.in_day;
        r.input_valid = ok;
        r.input_leap = is_leap_year(q.in_year);
        if (ok)
        begin
            if (q.req_type == REQ_NEXT)
            begin
                if (q.in_day < len)
                    r.out_day = q.in_day + 5'd1;
                else if (q.in_month < MONTH_DEC)
                begin
                    r.out_month = q.in_month + 4'd1;
                    r.out_day = DAY_FIRST;
                end
                else if (q.in_year < YEAR_MAX)
                begin
                    r.out_year = q.in_year + 14'd1;
                    r.out_month = MONTH_JAN;
                    r.out_day = DAY_FIRST;
                end
                else
                    r.range_limit = 1'b1;
            end
            else
            begin
                if (q.in_day > DAY_FIRST)
                    r.out_day = q.in_day - 5'd1;
                else if (q.in_month > MONTH_JAN)
                begin
                    r.out_month = q.in_month - 4'd1;
                    r.out_day = month_days(q.in_year, q.in_month - 4'd1);
                end
                else if (q.in_year > YEAR_MIN)
                begin
                    r.out_year = q.in_year - 14'd1;
                    r.out_month = MONTH_DEC;
                    r.out_day = DAY_LAST_DEC;
                end
                else
                    r.range_limit = 1'b1;
            end
        end
        pk = r.out_year * 32'd10000 + r.out_month * 32'd100 + r.out_day;
        r.packed_date = pk[26:0];
        return r;
    endfunction

    // mostly real dates, a third of them on month boundaries, plus raw noise
    function automatic date_req_t random_date();
        date_req_t   q;
        int unsigned kind;
        logic [13:0] yr;
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 15))
            0: yr = YEAR_MIN;
            1: yr = YEAR_MAX;
            2: yr = 14'd1900;
            3: yr = 14'd2000;
            4: yr = 14'd2100;
            default: yr = 14'($urandom_range(0, 9999));
        endcase
        q.in_year = yr;
        q.in_month = 4'($urandom_range(1, 12));
        q.req_type = 1'($urandom_range(0, 1));
        if (kind < 12)
        begin
            q.in_year = 14'($urandom_range(0, 16383));
            q.in_month = 4'($urandom_range(0, 15));
            q.in_day = 5'($urandom_range(0, 31));
        end
        else if (kind < 45)
        begin
            if ($urandom_range(0, 3) == 0)
                q.in_month = $urandom_range(0, 1) ? MONTH_JAN : MONTH_DEC;
            q.in_day = $urandom_range(0, 1) ? DAY_FIRST : month_days(yr, q.in_month);
        end
        else
            q.in_day = 5'($urandom_range(1, month_days(yr, q.in_month)));
        return q;
    endfunction

    task automatic add_predicted(input int y, m, d, input logic dir);
        date_row_t row;
        row.req = '{in_year: 14'(y), in_month: 4'(m), in_day: 5'(d), req_type: dir};
        row.fixed = 1'b0;
        row.rsp = '0;
        date_table.push_back(row);
    endtask

    task automatic add_known(input int y, m, d, input logic dir,
                             input int oy, om, od, pk,
                             input logic ok, leap, lim);
        date_row_t row;
        row.req = '{in_year: 14'(y), in_month: 4'(m), in_day: 5'(d), req_type: dir};
        row.fixed = 1'b1;
        row.rsp = '{out_year: 14'(oy), out_month: 4'(om), out_day: 5'(od),
                    packed_date: 27'(pk),
                    input_valid: ok, input_leap: leap, range_limit: lim};
        date_table.push_back(row);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_date(input date_req_t q, input date_rsp_t want);
        while ($urandom_range(0, 99) < send_idle)
        begin
            date_valid <= 1'b0;
            @(negedge clk);
        end
        date_valid <= 1'b1;
        date <= q;
        do
            @(posedge clk);
        while (!date_ready);
        expected_dates.push_back(want);
        @(negedge clk);
    endtask

    task automatic drain_requests();
        date_valid <= 1'b0;
        while (expected_dates.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [26:0] want, got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(negedge clk)
        result_ready <= ($urandom_range(0, 99) >= recv_idle);

    always @(posedge clk)
    begin : result_check
        date_rsp_t want;
        if (rst_n)
        begin
            if ((date_valid && date_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
            else if (result_valid && result_ready)
            begin
                if (expected_dates.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got %0d",
                             $time, result.packed_date);
                end
                else
                begin
                    want = expected_dates.pop_front();
                    check_field("out_year", 27'(want.out_year), 27'(result.out_year));
                    check_field("out_month", 27'(want.out_month), 27'(result.out_month));
                    check_field("out_day", 27'(want.out_day), 27'(result.out_day));
                    check_field("packed_date", want.packed_date, result.packed_date);
                    check_field("input_valid", 27'(want.input_valid),
                                27'(result.input_valid));
                    check_field("input_leap", 27'(want.input_leap), 27'(result.input_leap));
                    check_field("range_limit", 27'(want.range_limit),
                                27'(result.range_limit));
                end
            end
        end
    end

    initial
    begin : stimulus
        date_req_t q;
        // falling edge on rst_n at time zero so the asynchronous reset takes hold
        rst_n <= 1'b0;
        // range ends and malformed dates, expected values written out
        add_known(9999, MONTH_DEC, 31, REQ_NEXT, 9999, MONTH_DEC, 31, 99991231, 1, 0, 1);
        add_known(0, MONTH_JAN, 1, REQ_PREV, 0, MONTH_JAN, 1, 101, 1, 1, 1);
        add_known(2024, 0, 10, REQ_NEXT, 2024, 0, 10, 20240010, 0, 1, 0);
        add_known(2023, 15, 31, REQ_PREV, 2023, 15, 31, 20231531, 0, 0, 0);
        add_known(2023, MONTH_FEB, 29, REQ_NEXT, 2023, MONTH_FEB, 29, 20230229, 0, 0, 0);
        add_known(2024, MONTH_MAY, 0, REQ_PREV, 2024, MONTH_MAY, 0, 20240500, 0, 1, 0);
        add_known(2023, MONTH_APR, 31, REQ_NEXT, 2023, MONTH_APR, 31, 20230431, 0, 0, 0);
        // out-of-range fields; the largest packed value wraps at 27 bits
        add_known(16383, 15, 31, REQ_NEXT, 16383, 15, 31, 29613803, 0, 0, 0);
        add_known(10000, MONTH_JAN, 1, REQ_NEXT, 10000, MONTH_JAN, 1, 100000101, 0, 1, 0);
        add_known(0, 0, 0, REQ_NEXT, 0, 0, 0, 0, 0, 1, 0);
        // month and year rollovers, leap rules
        add_predicted(2024, MONTH_FEB, 28, REQ_NEXT);
        add_predicted(2024, MONTH_FEB, 29, REQ_NEXT);
        add_predicted(2023, MONTH_FEB, 28, REQ_NEXT);
        add_predicted(2024, MONTH_MAR, 1, REQ_PREV);
        add_predicted(1900, MONTH_MAR, 1, REQ_PREV);
        add_predicted(2000, MONTH_MAR, 1, REQ_PREV);
        add_predicted(2023, MONTH_DEC, 31, REQ_NEXT);
        add_predicted(2024, MONTH_JAN, 1, REQ_PREV);
        add_predicted(9999, MONTH_DEC, 31, REQ_PREV);
        add_predicted(0, MONTH_JAN, 1, REQ_NEXT);
        add_predicted(9998, MONTH_DEC, 31, REQ_NEXT);
        add_predicted(1, MONTH_JAN, 1, REQ_PREV);
        add_predicted(2023, MONTH_APR, 30, REQ_NEXT);
        add_predicted(2023, MONTH_MAY, 1, REQ_PREV);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (date_table[i])
            send_date(date_table[i].req,
                      date_table[i].fixed ? date_table[i].rsp : step_date(date_table[i].req));
        drain_requests();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 8 : (phase == 1) ? 81 : 0;
            recv_idle = (phase == 0) ? 81 : (phase == 1) ? 8 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                q = random_date();
                send_date(q, step_date(q));
            end
            drain_requests();
        end

        repeat (8) @(posedge clk);
        if (errors == 0 && expected_dates.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
